@@ rtl/npe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the next-permutation engine.
// Used by npe_core and next_permutation_engine; depends on nothing.
package npe_pkg;

    localparam int MAX_ELEMS  = 16;
    localparam int ELEM_WIDTH = 16;
    localparam int IDX_W      = $clog2(MAX_ELEMS);
    localparam int CFG_W      = 5;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SCAN,
        PH_FIND,
        PH_SWAP,
        PH_REV_RL,
        PH_REV_RH,
        PH_REV_WH,
        PH_REV_WL,
        PH_EM_RD,
        PH_EM_WR
    } npe_phase_t;

    // one result word handed from the core to the output stage
    typedef struct packed {
        logic [IDX_W-1:0]      position;
        logic [ELEM_WIDTH-1:0] element;
        logic                  advanced;
        logic                  last;
    } npe_word_t;

endpackage

@@ rtl/npe_core.sv @@
`timescale 1ns / 1ps
// Element store and advance sequencer of the next-permutation engine.
// Depends on npe_pkg; the store is a one-read, one-write synchronous RAM.
module npe_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [3:0]                      index,
    input  logic [15:0]                     value,
    input  logic [npe_pkg::CFG_W-1:0]       active_size,
    input  logic                            push_ok,
    output logic                            push,
    output npe_pkg::npe_word_t              word
);
    import npe_pkg::*;

    logic [ELEM_WIDTH-1:0] store_mem [MAX_ELEMS];
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;

    npe_phase_t            state_reg, state_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [IDX_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      piv_reg, piv_next;
    logic [IDX_W-1:0]      swp_reg, swp_next;
    logic [ELEM_WIDTH-1:0] hold_reg, hold_next;
    logic [ELEM_WIDTH-1:0] pv_reg, pv_next;
    logic                  first_reg, first_next;
    logic                  adv_reg, adv_next;

    logic [CFG_W-1:0]      n_sat;
    logic [IDX_W-1:0]      last_idx;
    logic                  accept;

    assign n_sat    = (active_size > CFG_W'(MAX_ELEMS)) ? CFG_W'(MAX_ELEMS) : active_size;
    assign last_idx = IDX_W'(n_sat - CFG_W'(1));
    assign in_ready = (state_reg == PH_IDLE);
    assign accept   = in_valid && in_ready;

    // store: contents stay undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
            ptr_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            piv_reg   <= '0;
            swp_reg   <= '0;
            first_reg <= 1'b0;
            adv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            piv_reg   <= piv_next;
            swp_reg   <= swp_next;
            first_reg <= first_next;
            adv_reg   <= adv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        pv_reg   <= pv_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        piv_next   = piv_reg;
        swp_next   = swp_reg;
        hold_next  = hold_reg;
        pv_next    = pv_reg;
        first_next = first_reg;
        adv_next   = adv_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data_reg;
        push       = 1'b0;
        word.position = ptr_reg;
        word.element  = rd_data_reg;
        word.advanced = adv_reg;
        word.last     = (ptr_reg == IDX_W'(MAX_ELEMS - 1));

        case (state_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    if (!cmd)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(index);
                        wr_data = ELEM_WIDTH'(value);
                    end
                    else if (n_sat < CFG_W'(2))
                    begin
                        // nothing to permute: emit unchanged
                        adv_next   = 1'b0;
                        piv_next   = '0;
                        swp_next   = '0;
                        ptr_next   = '0;
                        state_next = PH_EM_RD;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = last_idx;
                        ptr_next   = last_idx;
                        first_next = 1'b1;
                        state_next = PH_SCAN;
                    end
                end
            end

            // walk down from the end; hold_reg has the element right of ptr
            PH_SCAN:
            begin
                if (!first_reg && (rd_data_reg < hold_reg))
                begin
                    piv_next   = ptr_reg;
                    pv_next    = rd_data_reg;
                    rd_en      = 1'b1;
                    rd_addr    = last_idx;
                    ptr_next   = last_idx;
                    state_next = PH_FIND;
                end
                else if (ptr_reg == '0)
                begin
                    // no ascent: reverse the whole active part
                    adv_next   = 1'b0;
                    piv_next   = '0;
                    swp_next   = '0;
                    lo_next    = '0;
                    hi_next    = last_idx;
                    state_next = PH_REV_RL;
                end
                else
                begin
                    hold_next  = rd_data_reg;
                    first_next = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg - IDX_W'(1);
                    ptr_next   = ptr_reg - IDX_W'(1);
                end
            end

            // rightmost element above the pivot value; one always exists
            PH_FIND:
            begin
                if (rd_data_reg > pv_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = piv_reg;
                    wr_data    = rd_data_reg;
                    swp_next   = ptr_reg;
                    state_next = PH_SWAP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - IDX_W'(1);
                    ptr_next = ptr_reg - IDX_W'(1);
                end
            end

            PH_SWAP:
            begin
                wr_en      = 1'b1;
                wr_addr    = swp_reg;
                wr_data    = pv_reg;
                adv_next   = 1'b1;
                lo_next    = piv_reg + IDX_W'(1);
                hi_next    = last_idx;
                state_next = PH_REV_RL;
            end

            PH_REV_RL:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lo_reg;
                    state_next = PH_REV_RH;
                end
                else
                begin
                    ptr_next   = '0;
                    state_next = PH_EM_RD;
                end
            end

            PH_REV_RH:
            begin
                hold_next  = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = hi_reg;
                state_next = PH_REV_WH;
            end

            PH_REV_WH:
            begin
                wr_en      = 1'b1;
                wr_addr    = hi_reg;
                wr_data    = hold_reg;
                state_next = PH_REV_WL;
            end

            // read data still holds the old high element
            PH_REV_WL:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = rd_data_reg;
                lo_next    = lo_reg + IDX_W'(1);
                hi_next    = hi_reg - IDX_W'(1);
                state_next = PH_REV_RL;
            end

            PH_EM_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = PH_EM_WR;
            end

            // hold the word until the output stage has room
            PH_EM_WR:
            begin
                if (push_ok)
                begin
                    push = 1'b1;
                    if (ptr_reg == IDX_W'(MAX_ELEMS - 1))
                    begin
                        state_next = PH_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + IDX_W'(1);
                        state_next = PH_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = PH_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/next_permutation_engine.sv @@
`timescale 1ns / 1ps
// Next-permutation engine: one item at a time. An advance over n active entries
// scans for the pivot, finds the swap partner, swaps, reverses the tail pair by
// pair (no pivot: reverses the whole active part; n < 2: none of these), then
// emits all 16 words via the single store read port, waiting on a full output.
// rst_n clears the sequencer, the output valid flag and active_size (to 16);
// the element store is not cleared and must be written before it is read.
module next_permutation_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [3:0]                    index,
    input  logic [15:0]                   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    position,
    output logic [15:0]                   element,
    output logic                          advanced,
    output logic                          last,
    input  logic                          cfg_wr_en,
    input  logic [npe_pkg::CFG_W-1:0]     cfg_wr_data
);
    import npe_pkg::*;

    logic [CFG_W-1:0] size_reg;
    logic             out_valid_reg;
    npe_word_t        out_word_reg;
    npe_word_t        core_word;
    logic             core_push;
    logic             push_ok;

    assign push_ok = !out_valid_reg || out_ready;

    npe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .index       (index),
        .value       (value),
        .active_size (size_reg),
        .push_ok     (push_ok),
        .push        (core_push),
        .word        (core_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= CFG_W'(MAX_ELEMS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            if (core_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_push)
        begin
            out_word_reg <= core_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = out_word_reg.position;
    assign element   = out_word_reg.element;
    assign advanced  = out_word_reg.advanced;
    assign last      = out_word_reg.last;

    // a word is never pushed over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        core_push |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    // the run ends exactly at the top position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (position == IDX_W'(MAX_ELEMS - 1)))
        else $error("last flag away from final position");

    // no new item is taken while a run is still being emitted
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (core_push && !core_word.last) |=> !in_ready)
        else $error("input accepted mid-run");

endmodule

@@ tb/next_permutation_engine_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for next_permutation_engine. A scoreboard class keeps its
// own copy of the element array and predicts every emitted word.
// Depends on npe_pkg and the engine RTL.
module next_permutation_engine_test;

    import npe_pkg::*;

    localparam logic CMD_WRITE      = 1'b0;
    localparam logic CMD_ADVANCE    = 1'b1;
    localparam int   ITEM_TARGET    = 270;
    localparam int   DRAIN_CYCLES   = 200;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   WATCHDOG_LIMIT = 3000;
    localparam int   REPORT_CAP     = 40;

    class perm_scoreboard;
        logic [ELEM_WIDTH-1:0] elems [MAX_ELEMS];
        logic [CFG_W-1:0]      span;
        npe_word_t             expected_words [$];
        int                    errors;

        function new();
            span   = 5'd16;
            errors = 0;
        endfunction

        function void set_span(logic [CFG_W-1:0] s);
            span = s;
        endfunction

        function int words_outstanding();
            return expected_words.size();
        endfunction

        function void flip_run(int lo, int hi);
            logic [ELEM_WIDTH-1:0] t;
            while (lo + 1 < hi)
            begin
                hi--;
                t         = elems[lo];
                elems[lo] = elems[hi];
                elems[hi] = t;
                lo++;
            end
        endfunction

        // Returns 1 when a successor exists, else 0 (wrap to sorted order, or n < 2).
        function logic step_permutation();
            int n;
            int p;
            int q;
            logic [ELEM_WIDTH-1:0] t;
            n = (span > MAX_ELEMS) ? MAX_ELEMS : int'(span);
            if (n < 2)
                return 1'b0;
            p = n - 1;
            while (p > 0 && elems[p-1] >= elems[p])
                p--;
            if (p == 0)
            begin
                flip_run(0, n);
                return 1'b0;
            end
            q = n - 1;
            while (q > p && elems[q] <= elems[p-1])
                q--;
            t          = elems[p-1];
            elems[p-1] = elems[q];
            elems[q]   = t;
            flip_run(p, n);
            return 1'b1;
        endfunction

        function void note_item(logic c, logic [IDX_W-1:0] idx, logic [ELEM_WIDTH-1:0] val);
            npe_word_t w;
            logic      adv;
            if (c == CMD_WRITE)
            begin
                elems[idx] = val;
                return;
            end
            adv = step_permutation();
            for (int k = 0; k < MAX_ELEMS; k++)
            begin
                w.position = IDX_W'(k);
                w.element  = elems[k];
                w.advanced = adv;
                w.last     = (k == MAX_ELEMS - 1);
                expected_words.push_back(w);
            end
        endfunction

        function void report(string what, int exp_v, int got_v);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t ns: %s expected %0h got %0h", $time, what, exp_v, got_v);
        endfunction

        function void check_word(npe_word_t got);
            npe_word_t exp_w;
            if (expected_words.size() == 0)
            begin
                report("unexpected word, position", -1, got.position);
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.position !== exp_w.position)
                report("position", exp_w.position, got.position);
            if (got.element !== exp_w.element)
                report("element", exp_w.element, got.element);
            if (got.advanced !== exp_w.advanced)
                report("advanced", exp_w.advanced, got.advanced);
            if (got.last !== exp_w.last)
                report("last", exp_w.last, got.last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  cmd;
    logic [3:0]            index;
    logic [15:0]           value;
    logic                  out_valid;
    logic                  out_ready;
    logic [3:0]            position;
    logic [15:0]           element;
    logic                  advanced;
    logic                  last;
    logic                  cfg_wr_en;
    logic [CFG_W-1:0]      cfg_wr_data;

    perm_scoreboard        sb;
    int                    burst_left;
    int                    items_sent;
    int                    stall_cycles;
    bit                    hold_off;
    logic [15:0]           seed_values [16];
    int                    size_plan [9];

    next_permutation_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .index       (index),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .position    (position),
        .element     (element),
        .advanced    (advanced),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: patterns of random length, plus one long hold-off on request.
    initial
    begin
        int mode;
        int stretch_left;
        int rx_tick;
        mode         = 0;
        stretch_left = 0;
        rx_tick      = 0;
        out_ready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    mode         = $urandom_range(0, 3);
                    stretch_left = $urandom_range(10, 60);
                end
                stretch_left--;
                rx_tick++;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((rx_tick % 5) != 0);
                endcase
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_item(cmd, index, value);
            if (out_valid && out_ready)
                sb.check_word({position, element, advanced, last});
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic put_word(input logic c, input logic [3:0] i, input logic [15:0] v);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        index    <= i;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Drop valid, wait for every expected word, then let the block go quiet.
    task automatic finish_phase();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.words_outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] s);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= s;
        @(posedge clk);
        sb.set_span(s);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int sz, input bit stall_output);
        int          n;
        int          style;
        logic [15:0] fill;
        logic [15:0] v;
        write_size(sz[CFG_W-1:0]);
        n = (sz > MAX_ELEMS) ? MAX_ELEMS : sz;
        if (!stall_output && $urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(4, 12))
                put_word(1'($urandom_range(0, 1)), 4'($urandom), 16'($urandom));
        end
        else
        begin
            style = $urandom_range(0, 3);
            fill  = 16'($urandom);
            if ($urandom_range(0, 2) == 0)
                put_word(CMD_WRITE, 4'($urandom), 16'($urandom));
            for (int k = 0; k < n; k++)
            begin
                case (style)
                    0: v = 16'($urandom_range(0, 3));
                    1: v = 16'($urandom);
                    2: v = 16'((n - k) * 997);
                    default: v = fill;
                endcase
                put_word(CMD_WRITE, 4'(k), v);
            end
            // Stall the output while the sender keeps offering advances.
            if (stall_output)
                hold_off = 1'b1;
            repeat ((n <= 3) ? 8 : $urandom_range(2, 6))
            begin
                if ($urandom_range(0, 7) == 0)
                    put_word(CMD_WRITE, 4'($urandom), 16'($urandom));
                put_word(CMD_ADVANCE, 4'($urandom), 16'($urandom));
            end
        end
        finish_phase();
    endtask

    initial
    begin
        int phase;
        int sz;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_WRITE;
        index        = '0;
        value        = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        hold_off     = 1'b0;
        burst_left   = 0;
        items_sent   = 0;
        stall_cycles = 0;
        seed_values  = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA,
                         16'h5555, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFE, 16'h00FF,
                         16'hFF00, 16'h0F0F, 16'hF0F0, 16'h8001};
        size_plan    = '{2, 4, 17, 0, 5, 1, 16, 3, 31};
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (5) @(negedge clk);

        // Full array with extreme and repeated values.
        write_size(5'd16);
        for (int k = 0; k < MAX_ELEMS; k++)
            put_word(CMD_WRITE, 4'(k), seed_values[k]);
        put_word(CMD_ADVANCE, 4'hF, 16'hFFFF);
        put_word(CMD_ADVANCE, 4'h0, 16'h0000);
        finish_phase();

        // Descending run with a repeat: wrap first, then walk the multiset.
        write_size(5'd3);
        put_word(CMD_WRITE, 4'd0, 16'd7);
        put_word(CMD_WRITE, 4'd1, 16'd7);
        put_word(CMD_WRITE, 4'd2, 16'd3);
        repeat (3) put_word(CMD_ADVANCE, 4'($urandom), 16'($urandom));
        finish_phase();

        // Size zero, size one, and a size past the array end.
        write_size(5'd0);
        put_word(CMD_ADVANCE, 4'd5, 16'h0F0F);
        finish_phase();
        write_size(5'd1);
        put_word(CMD_ADVANCE, 4'd9, 16'hF0F0);
        finish_phase();
        write_size(5'd31);
        put_word(CMD_ADVANCE, 4'd3, 16'h3C3C);
        finish_phase();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < 9)
                sz = size_plan[phase];
            else if ($urandom_range(0, 3) == 0)
                sz = $urandom_range(0, 31);
            else
                sz = $urandom_range(2, 6);
            run_phase(sz, phase == 0);
            phase++;
        end

        if (sb.errors == 0 && sb.words_outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
